>>> rtl/tshp_pkg.sv
// Package for the TLS ServerHello parser.
// Holds the parse state and result types, phase codes and protocol constants.
// No dependencies.
package tshp_pkg;

    localparam int MAX_EXTENSIONS_DEF = 32;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_HDR     = 4'd1;
    localparam logic [3:0] PH_RANDOM  = 4'd2;
    localparam logic [3:0] PH_SIDLEN  = 4'd3;
    localparam logic [3:0] PH_SID     = 4'd4;
    localparam logic [3:0] PH_CIPHER  = 4'd5;
    localparam logic [3:0] PH_COMP    = 4'd6;
    localparam logic [3:0] PH_EXTLEN  = 4'd7;
    localparam logic [3:0] PH_EXTHDR  = 4'd8;
    localparam logic [3:0] PH_EXTSKIP = 4'd9;
    localparam logic [3:0] PH_GROUP   = 4'd10;

    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_SERVER_HELLO = 8'h02;
    localparam logic [15:0] REC_VER_MIN     = 16'h0301;
    localparam logic [15:0] TLS12_VERSION   = 16'h0303;
    localparam logic [15:0] HDR_BYTES       = 16'd11;
    localparam logic [15:0] RANDOM_BYTES    = 16'd32;
    localparam logic [15:0] EXT_HDR_BYTES   = 16'd4;
    localparam logic [15:0] FIELD16_BYTES   = 16'd2;

    localparam logic [1:0] CFG_TARGET_EXT = 2'd0;
    localparam logic [1:0] CFG_MIN_LEN    = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN    = 2'd2;

    localparam logic [15:0] TARGET_EXT_RST = 16'd51;
    localparam logic [14:0] MIN_LEN_RST    = 15'd40;
    localparam logic [14:0] MAX_LEN_RST    = 15'd16384;

    typedef struct packed {
        logic [3:0]  phase;
        logic [14:0] rec_offset;
        logic [14:0] rec_length;
        logic [15:0] skip;
        logic [31:0] shift;
        logic [15:0] cipher;
        logic        done;
        logic [31:0] bad_count;
    } t_parse_state;

    typedef struct packed {
        logic        status;
        logic [15:0] cipher_suite;
        logic [15:0] named_group;
        logic [31:0] invalid_count;
    } t_result;

endpackage

>>> rtl/tls_server_hello_parser.sv
// Top level of the TLS ServerHello parser: stream ports, input and result registers,
// configuration registers. Depends on tshp_pkg and tshp_step.
//
// Channel    Dir  Handshake                       Payload
// s_axis     in   s_axis_tvalid / s_axis_tready   tdata: data_byte; tuser: kind, message_start
// m_axis     out  m_axis_tvalid / m_axis_tready   tdata: cipher, group, count; tuser: status
// cfg        in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One item is accepted per cycle while the result register is empty or being taken; an item
// is held in the input register and any result it yields in the result register. The rate
// is set by the single state update between these two registers, which runs once per cycle.
// Reset is synchronous and active low; it restores the register defaults and idles the parser.
// While a result is not taken, the parser holds one item in its input register and then
// stalls the input. Configuration writes are accepted in every cycle.
module tls_server_hello_parser #(
    parameter int MAX_EXTENSIONS = tshp_pkg::MAX_EXTENSIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [0] kind, [1] message_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] cipher_suite, [31:16] named_group,
                                        // [63:32] invalid_count
    output logic        m_axis_tuser,   // [0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tshp_pkg::*;

    localparam int EXT_W = $clog2(MAX_EXTENSIONS + 1);

    logic             r_in_valid;
    logic             r_in_kind;
    logic [7:0]       r_in_byte;
    logic             r_in_start;
    t_parse_state     r_state;
    logic [EXT_W-1:0] r_ext_idx;
    logic             r_out_valid;
    t_result          r_out;
    logic [15:0]      r_target_ext;
    logic [14:0]      r_min_len;
    logic [14:0]      r_max_len;

    t_parse_state     n_state;
    logic [EXT_W-1:0] n_ext_idx;
    t_result          n_out;
    logic             step_emit;
    logic             proc;

    tshp_step #(
        .MAX_EXTENSIONS(MAX_EXTENSIONS)
    ) u_step (
        .i_state     (r_state),
        .i_ext_idx   (r_ext_idx),
        .i_kind      (r_in_kind),
        .i_byte      (r_in_byte),
        .i_msg_start (r_in_start),
        .i_target_ext(r_target_ext),
        .i_min_len   (r_min_len),
        .i_max_len   (r_max_len),
        .o_state     (n_state),
        .o_ext_idx   (n_ext_idx),
        .o_emit      (step_emit),
        .o_result    (n_out)
    );

    assign proc          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.invalid_count, r_out.named_group, r_out.cipher_suite};
    assign m_axis_tuser  = r_out.status;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_ext_idx   <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_state   <= n_state;
                r_ext_idx <= n_ext_idx;
            end
            if (proc && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind  <= s_axis_tuser[0];
            r_in_start <= s_axis_tuser[1];
            r_in_byte  <= s_axis_tdata;
        end
        if (proc && step_emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_ext <= TARGET_EXT_RST;
            r_min_len    <= MIN_LEN_RST;
            r_max_len    <= MAX_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TARGET_EXT: r_target_ext <= i_cfg_data;
                CFG_MIN_LEN:    r_min_len    <= i_cfg_data[14:0];
                CFG_MAX_LEN:    r_max_len    <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/tshp_step.sv
// Next-state logic of the ServerHello parser for one item.
// Depends on tshp_pkg for the state and result types and the phase codes.
module tshp_step #(
    parameter int MAX_EXTENSIONS = tshp_pkg::MAX_EXTENSIONS_DEF,
    localparam int EXT_W = $clog2(MAX_EXTENSIONS + 1)
) (
    input  tshp_pkg::t_parse_state i_state,
    input  logic [EXT_W-1:0]       i_ext_idx,
    input  logic                   i_kind,
    input  logic [7:0]             i_byte,
    input  logic                   i_msg_start,
    input  logic [15:0]            i_target_ext,
    input  logic [14:0]            i_min_len,
    input  logic [14:0]            i_max_len,
    output tshp_pkg::t_parse_state o_state,
    output logic [EXT_W-1:0]       o_ext_idx,
    output logic                   o_emit,
    output tshp_pkg::t_result      o_result
);
    import tshp_pkg::*;

    function automatic t_parse_state clear_parse(input t_parse_state s);
        t_parse_state c;
        c            = s;
        c.phase      = PH_IDLE;
        c.rec_offset = '0;
        c.rec_length = '0;
        c.skip       = '0;
        c.shift      = '0;
        c.cipher     = '0;
        return c;
    endfunction

    always_comb begin
        t_parse_state     s;
        logic [EXT_W-1:0] idx;
        logic             go;
        logic             abort;
        logic             fin;
        logic             fin_bad;
        logic [15:0]      fin_group;
        logic             walk_next;
        logic [3:0]       pos;
        logic [15:0]      v;
        logic [31:0]      cnt;

        s         = i_state;
        idx       = i_ext_idx;
        go        = 1'b0;
        abort     = 1'b0;
        fin       = 1'b0;
        fin_bad   = 1'b0;
        fin_group = '0;
        walk_next = 1'b0;
        pos       = '0;
        v         = '0;
        cnt       = i_state.bad_count;
        o_emit    = 1'b0;
        o_result  = '0;

        if (!i_kind) begin
            s      = clear_parse(i_state);
            s.done = 1'b0;
            idx    = '0;
        end else if (!i_state.done) begin
            go = 1'b1;
            if (s.phase == PH_IDLE) begin
                if (!i_msg_start) begin
                    go = 1'b0;
                end else begin
                    s       = clear_parse(s);
                    idx     = '0;
                    s.phase = PH_HDR;
                    s.skip  = HDR_BYTES;
                end
            end
        end

        if (go) begin
            s.shift = {s.shift[23:0], i_byte};
            if (s.phase != PH_HDR) begin
                s.rec_offset = s.rec_offset + 15'd1;
            end
            v = s.shift[15:0];
            case (s.phase)
                PH_HDR: begin
                    if (s.skip == 16'd0 || s.skip > HDR_BYTES) begin
                        abort = 1'b1;
                    end else begin
                        pos    = 4'(HDR_BYTES - s.skip);
                        s.skip = s.skip - 16'd1;
                        if (pos >= 4'd5) begin
                            s.rec_offset = s.rec_offset + 15'd1;
                        end
                        if ((pos == 4'd0 && i_byte != REC_HANDSHAKE) ||
                            (pos == 4'd2 && (v < REC_VER_MIN || v > TLS12_VERSION)) ||
                            (pos == 4'd4 && (v <= {1'b0, i_min_len} ||
                                             v > {1'b0, i_max_len})) ||
                            (pos == 4'd5 && i_byte != HS_SERVER_HELLO) ||
                            (pos == 4'd10 && v != TLS12_VERSION)) begin
                            abort = 1'b1;
                        end else begin
                            if (pos == 4'd4) begin
                                s.rec_length = v[14:0];
                            end
                            if (pos == 4'd10) begin
                                s.phase = PH_RANDOM;
                                s.skip  = RANDOM_BYTES;
                            end
                        end
                    end
                end
                PH_RANDOM: begin
                    s.skip = s.skip - 16'd1;
                    if (s.skip == 16'd0) begin
                        s.phase = PH_SIDLEN;
                    end
                end
                PH_SIDLEN: begin
                    if (i_byte != 8'd0) begin
                        s.skip  = {8'd0, i_byte};
                        s.phase = PH_SID;
                    end else begin
                        s.skip  = FIELD16_BYTES;
                        s.phase = PH_CIPHER;
                    end
                end
                PH_SID: begin
                    s.skip = s.skip - 16'd1;
                    if (s.skip == 16'd0) begin
                        s.phase = PH_CIPHER;
                        s.skip  = FIELD16_BYTES;
                    end
                end
                PH_CIPHER: begin
                    s.skip = s.skip - 16'd1;
                    if (s.skip == 16'd0) begin
                        s.cipher = v;
                        s.phase  = PH_COMP;
                    end
                end
                PH_COMP: begin
                    if (i_byte != 8'd0) begin
                        fin     = 1'b1;
                        fin_bad = 1'b1;
                    end else begin
                        s.phase = PH_EXTLEN;
                        s.skip  = FIELD16_BYTES;
                    end
                end
                PH_EXTLEN: begin
                    s.skip = s.skip - 16'd1;
                    if (s.skip == 16'd0) begin
                        s.phase = PH_EXTHDR;
                        s.skip  = EXT_HDR_BYTES;
                    end
                end
                PH_EXTHDR, PH_EXTSKIP: begin
                    s.skip = s.skip - 16'd1;
                    if (s.skip == 16'd0) begin
                        walk_next = 1'b1;
                        if (s.phase == PH_EXTHDR) begin
                            if (s.shift[31:16] == i_target_ext) begin
                                s.phase   = PH_GROUP;
                                s.skip    = FIELD16_BYTES;
                                walk_next = 1'b0;
                            end else if (v != 16'd0) begin
                                s.phase   = PH_EXTSKIP;
                                s.skip    = v;
                                walk_next = 1'b0;
                            end
                        end
                        if (walk_next) begin
                            idx = idx + EXT_W'(1);
                            if (s.rec_offset >= s.rec_length ||
                                idx >= EXT_W'(MAX_EXTENSIONS)) begin
                                fin = 1'b1;
                            end else begin
                                s.phase = PH_EXTHDR;
                                s.skip  = EXT_HDR_BYTES;
                            end
                        end
                    end
                end
                PH_GROUP: begin
                    s.skip = s.skip - 16'd1;
                    if (s.skip == 16'd0) begin
                        fin       = 1'b1;
                        fin_group = v;
                    end
                end
                default: begin
                    abort = 1'b1;
                end
            endcase

            if (!fin && !abort && s.phase != PH_IDLE && s.phase != PH_HDR &&
                s.rec_offset >= s.rec_length) begin
                fin     = 1'b1;
                fin_bad = 1'b1;
            end

            if (abort) begin
                s   = clear_parse(s);
                idx = '0;
            end else if (fin) begin
                if (fin_bad && cnt != '1) begin
                    cnt = cnt + 32'd1;
                end
                o_emit                 = 1'b1;
                o_result.status        = fin_bad;
                o_result.cipher_suite  = fin_bad ? 16'd0 : s.cipher;
                o_result.named_group   = fin_bad ? 16'd0 : fin_group;
                o_result.invalid_count = cnt;
                s                      = clear_parse(s);
                s.bad_count            = cnt;
                s.done                 = 1'b1;
                idx                    = '0;
            end
        end

        o_state   = s;
        o_ext_idx = idx;
    end

endmodule

>>> tb/tb_tls_server_hello_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for tls_server_hello_parser: drives TCP stream bytes and
// connection events, predicts each ServerHello result and checks it field by field.
// Depends on tshp_pkg and the RTL of tls_server_hello_parser.
module tb_tls_server_hello_parser;
    import tshp_pkg::*;

    localparam logic KIND_CONNECT  = 1'b0;
    localparam logic KIND_BYTE     = 1'b1;
    localparam int   REC_HDR_BYTES = 5;
    localparam int   CYCLE_LIMIT   = 1000000;
    localparam int   LONG_HOLD     = 400;

    class hello_scoreboard;
        logic [15:0] target_ext;
        int unsigned min_len;
        int unsigned max_len;
        logic [3:0]  phase;
        int unsigned rec_off;
        int unsigned rec_len;
        int unsigned skip_left;
        int unsigned ext_count;
        logic [31:0] shift_reg;
        logic [15:0] cipher_reg;
        bit          conn_done;
        logic [31:0] bad_total;
        t_result     pending_hellos[$];
        int          mismatches;

        function new();
            target_ext = TARGET_EXT_RST;
            min_len    = MIN_LEN_RST;
            max_len    = MAX_LEN_RST;
            conn_done  = 1'b0;
            bad_total  = '0;
            mismatches = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase      = PH_IDLE;
            rec_off    = 0;
            rec_len    = 0;
            skip_left  = 0;
            ext_count  = 0;
            shift_reg  = '0;
            cipher_reg = '0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_TARGET_EXT: target_ext = value;
                CFG_MIN_LEN:    min_len = value[14:0];
                CFG_MAX_LEN:    max_len = value[14:0];
                default: ;
            endcase
        endfunction

        function void close_hello(bit bad, logic [15:0] group);
            t_result res;
            if (bad && bad_total != '1)
                bad_total++;
            res.status        = bad;
            res.cipher_suite  = bad ? 16'h0 : cipher_reg;
            res.named_group   = bad ? 16'h0 : group;
            res.invalid_count = bad_total;
            pending_hellos.push_back(res);
            clear_parse();
            conn_done = 1'b1;
        endfunction

        function void parse_hello_byte(logic kind, logic [7:0] value, logic start);
            int unsigned pos;
            int unsigned v;
            if (kind == KIND_CONNECT) begin
                clear_parse();
                conn_done = 1'b0;
                return;
            end
            if (conn_done)
                return;
            if (phase == PH_IDLE) begin
                if (!start)
                    return;
                clear_parse();
                phase = PH_HDR;
                skip_left = HDR_BYTES;
            end
            shift_reg = {shift_reg[23:0], value};
            if (phase != PH_HDR)
                rec_off = (rec_off + 1) & 32'h7FFF;
            v = shift_reg[15:0];
            case (phase)
                PH_HDR: begin
                    if (skip_left < 1 || skip_left > HDR_BYTES) begin
                        clear_parse();
                        return;
                    end
                    pos = HDR_BYTES - skip_left;
                    skip_left--;
                    if (pos >= 5)
                        rec_off++;
                    if ((pos == 0 && value != REC_HANDSHAKE) ||
                        (pos == 2 && (v < REC_VER_MIN || v > TLS12_VERSION)) ||
                        (pos == 4 && (v <= min_len || v > max_len)) ||
                        (pos == 5 && value != HS_SERVER_HELLO) ||
                        (pos == 10 && v != TLS12_VERSION)) begin
                        clear_parse();
                        return;
                    end
                    if (pos == 4)
                        rec_len = v & 32'h7FFF;
                    if (pos == 10) begin
                        phase = PH_RANDOM;
                        skip_left = RANDOM_BYTES;
                    end
                end
                PH_RANDOM: begin
                    skip_left--;
                    if (skip_left == 0)
                        phase = PH_SIDLEN;
                end
                PH_SIDLEN: begin
                    skip_left = (value != 0) ? value : FIELD16_BYTES;
                    phase = (value != 0) ? PH_SID : PH_CIPHER;
                end
                PH_SID: begin
                    skip_left--;
                    if (skip_left == 0) begin
                        phase = PH_CIPHER;
                        skip_left = FIELD16_BYTES;
                    end
                end
                PH_CIPHER: begin
                    skip_left--;
                    if (skip_left == 0) begin
                        cipher_reg = shift_reg[15:0];
                        phase = PH_COMP;
                    end
                end
                PH_COMP: begin
                    if (value != 0) begin
                        close_hello(1'b1, 16'h0);
                        return;
                    end
                    phase = PH_EXTLEN;
                    skip_left = FIELD16_BYTES;
                end
                PH_EXTLEN: begin
                    skip_left--;
                    if (skip_left == 0) begin
                        phase = PH_EXTHDR;
                        skip_left = EXT_HDR_BYTES;
                    end
                end
                PH_EXTHDR, PH_EXTSKIP: begin
                    skip_left--;
                    if (skip_left == 0) begin
                        if (phase == PH_EXTHDR && shift_reg[31:16] == target_ext) begin
                            phase = PH_GROUP;
                            skip_left = FIELD16_BYTES;
                        end else if (phase == PH_EXTHDR && shift_reg[15:0] != 0) begin
                            phase = PH_EXTSKIP;
                            skip_left = shift_reg[15:0];
                        end else begin
                            ext_count++;
                            if (rec_off >= rec_len || ext_count >= MAX_EXTENSIONS_DEF) begin
                                close_hello(1'b0, 16'h0);
                                return;
                            end
                            phase = PH_EXTHDR;
                            skip_left = EXT_HDR_BYTES;
                        end
                    end
                end
                PH_GROUP: begin
                    skip_left--;
                    if (skip_left == 0) begin
                        close_hello(1'b0, shift_reg[15:0]);
                        return;
                    end
                end
                default: begin
                    clear_parse();
                    return;
                end
            endcase
            // Every body byte still needed must lie inside the record.
            if (phase != PH_IDLE && phase != PH_HDR && rec_off >= rec_len)
                close_hello(1'b1, 16'h0);
        endfunction

        function void check_result(logic status, logic [15:0] cipher, logic [15:0] group,
                                   logic [31:0] count);
            t_result want;
            if (pending_hellos.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d cipher %h group %h count %0d",
                             status, cipher, group, count);
                return;
            end
            want = pending_hellos.pop_front();
            if (status !== want.status || cipher !== want.cipher_suite ||
                group !== want.named_group || count !== want.invalid_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected status %0d cipher %h group %h count %0d,",
                              " got status %0d cipher %h group %h count %0d"},
                             want.status, want.cipher_suite, want.named_group,
                             want.invalid_count, status, cipher, group, count);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    hello_scoreboard hello_sb;
    logic [7:0]      msg_q[$];
    int              comp_pos;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    bit              stall_request = 1'b0;
    bit              stall_taken = 1'b0;
    int              hold_left = 0;
    int              cycle_count = 0;

    tls_server_hello_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            hello_sb.parse_hello_byte(s_axis_tuser[0], s_axis_tdata, s_axis_tuser[1]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            hello_sb.check_result(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                                  m_axis_tdata[63:32]);
    end

    // The receiver takes one long hold-off on request so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_request && !stall_taken) begin
            stall_taken <= 1'b1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] value, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tuser <= {start, kind};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic new_connection();
        send_item(KIND_CONNECT, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_message(input int abort_at, input int start_pct);
        foreach (msg_q[i]) begin
            if (i == abort_at) begin
                new_connection();
                return;
            end
            send_item(KIND_BYTE, msg_q[i], i == 0 || $urandom_range(99) < start_pct);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hello_sb.pending_hellos.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        hello_sb.set_register(idx, value);
    endtask

    task automatic apply_settings(input logic [15:0] tgt, input logic [15:0] lo,
                                  input logic [15:0] hi);
        settle();
        write_register(CFG_TARGET_EXT, tgt);
        write_register(CFG_MIN_LEN, lo);
        write_register(CFG_MAX_LEN, hi);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void set_record_length(int len);
        msg_q[3] = len[15:8];
        msg_q[4] = len[7:0];
    endfunction

    function automatic void fix_length();
        set_record_length(msg_q.size() - REC_HDR_BYTES);
    endfunction

    function automatic void add_extension(logic [15:0] ext_type, int ext_len);
        msg_q.push_back(ext_type[15:8]);
        msg_q.push_back(ext_type[7:0]);
        msg_q.push_back(ext_len[15:8]);
        msg_q.push_back(ext_len[7:0]);
        repeat (ext_len) msg_q.push_back(8'($urandom));
    endfunction

    function automatic void build_hello(int sid_len, int n_ext, int tgt_pct, int ext_max);
        bit          is_target;
        logic [15:0] ext_type;
        int          ext_len;
        msg_q.delete();
        msg_q.push_back(REC_HANDSHAKE);
        msg_q.push_back(REC_VER_MIN[15:8]);
        msg_q.push_back(8'($urandom_range(1, 3)));
        msg_q.push_back(8'h00);
        msg_q.push_back(8'h00);
        msg_q.push_back(HS_SERVER_HELLO);
        repeat (3) msg_q.push_back(8'($urandom));
        msg_q.push_back(TLS12_VERSION[15:8]);
        msg_q.push_back(TLS12_VERSION[7:0]);
        repeat (RANDOM_BYTES) msg_q.push_back(8'($urandom));
        msg_q.push_back(8'(sid_len));
        repeat (sid_len) msg_q.push_back(8'($urandom));
        repeat (FIELD16_BYTES) msg_q.push_back(8'($urandom));
        comp_pos = msg_q.size();
        msg_q.push_back(8'h00);
        repeat (FIELD16_BYTES) msg_q.push_back(8'($urandom));
        repeat (n_ext) begin
            is_target = ($urandom_range(99) < tgt_pct);
            ext_type = is_target ? hello_sb.target_ext : 16'($urandom);
            ext_len = (is_target && $urandom_range(9) < 6) ? 2 : $urandom_range(0, ext_max);
            add_extension(ext_type, ext_len);
        end
        fix_length();
    endfunction

    task automatic random_hellos(input int count);
        int n_ext;
        int body_len;
        int abort_at;
        int roll;
        repeat (count) begin
            n_ext = ($urandom_range(19) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 6);
            build_hello(($urandom_range(2) == 0) ? 0 : $urandom_range(1, 32), n_ext, 30,
                        (n_ext > 8) ? 0 : 8);
            body_len = msg_q.size() - REC_HDR_BYTES;
            abort_at = -1;
            roll = $urandom_range(99);
            if (roll < 8)
                msg_q[$urandom_range(0, 10)] = 8'($urandom);
            else if (roll < 14)
                msg_q[comp_pos] = 8'($urandom_range(1, 255));
            else if (roll < 26)
                set_record_length($urandom_range(1, body_len - 1));
            else if (roll < 34)
                set_record_length(body_len + $urandom_range(1, 24));
            else if (roll < 40)
                abort_at = $urandom_range(1, msg_q.size() - 1);
            repeat ($urandom_range(0, 2))
                send_item(KIND_BYTE, 8'($urandom), $urandom_range(3) == 0);
            send_message(abort_at, 5);
            repeat ($urandom_range(0, 3))
                send_item(KIND_BYTE, 8'($urandom), $urandom_range(3) == 0);
            if ($urandom_range(9) != 0)
                new_connection();
        end
        new_connection();
    endtask

    initial begin
        int         patch_pos[8] = '{0, 2, 2, 1, 5, 10, 2, 2};
        logic [7:0] patch_val[8] = '{8'h17, 8'h00, 8'h04, 8'h02, 8'h01, 8'h02, 8'h01, 8'h03};
        int         short_len[4] = '{1, 3, 6, 7};
        hello_sb = new();
        send_idle_pct = 23;
        recv_idle_pct = 82;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_hello(0, 2, 100, 4);
        send_message(-1, 0);
        new_connection();
        build_hello(32, 4, 0, 8);
        send_message(-1, 0);
        new_connection();
        // Header bytes at and just outside their limits.
        foreach (patch_pos[k]) begin
            build_hello(1, 1, 0, 2);
            msg_q[patch_pos[k]] = patch_val[k];
            send_message(-1, 0);
            new_connection();
        end
        build_hello(0, 1, 0, 2);
        set_record_length(MIN_LEN_RST);
        send_message(-1, 0);
        new_connection();
        build_hello(0, 1, 0, 2);
        set_record_length(MIN_LEN_RST + 1);
        send_message(-1, 0);
        new_connection();
        build_hello(0, 1, 0, 2);
        set_record_length(MAX_LEN_RST + 1);
        send_message(-1, 0);
        new_connection();
        build_hello(4, 2, 0, 4);
        msg_q[comp_pos] = 8'h01;
        send_message(-1, 0);
        new_connection();
        // A target extension that declares no data still yields two group bytes.
        build_hello(0, 0, 0, 0);
        add_extension(hello_sb.target_ext, 0);
        add_extension(~hello_sb.target_ext, 3);
        fix_length();
        send_message(-1, 0);
        new_connection();
        build_hello(0, 0, 0, 0);
        repeat (34) add_extension(~hello_sb.target_ext, 0);
        fix_length();
        send_message(-1, 0);
        new_connection();
        build_hello(2, 3, 50, 4);
        send_message(20, 0);
        build_hello(0, 2, 100, 4);
        send_message(-1, 100);
        build_hello(0, 2, 100, 4);
        send_message(-1, 0);
        new_connection();
        build_hello(0, 0, 0, 0);
        add_extension(~hello_sb.target_ext, MAX_LEN_RST - (msg_q.size() - REC_HDR_BYTES) -
                      EXT_HDR_BYTES);
        fix_length();
        send_message(-1, 0);
        new_connection();

        apply_settings(TARGET_EXT_RST, 16'h0, MAX_LEN_RST);
        foreach (short_len[k]) begin
            build_hello(0, 1, 0, 2);
            set_record_length(short_len[k]);
            send_message(-1, 0);
            new_connection();
        end

        apply_settings(TARGET_EXT_RST, MIN_LEN_RST, MAX_LEN_RST);
        random_hellos(10);
        apply_settings(TARGET_EXT_RST, MAX_LEN_RST, MAX_LEN_RST);
        random_hellos(3);

        send_idle_pct = 82;
        recv_idle_pct = 23;
        apply_settings(16'h0000, 16'h0, MAX_LEN_RST);
        random_hellos(10);
        apply_settings(16'hFFFF, 16'($urandom_range(0, 43)), 16'($urandom_range(150, 400)));
        random_hellos(10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(16'($urandom), 16'($urandom_range(0, 43)), MAX_LEN_RST);
        stall_request = 1'b1;
        random_hellos(10);
        apply_settings(16'($urandom), 16'h0, 16'h0);
        random_hellos(3);

        settle();
        if (hello_sb.mismatches == 0 && hello_sb.pending_hellos.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
